[sv/lsp_pkg.sv]
`timescale 1ns / 1ps

package lsp_pkg;

  localparam int SLOTS        = 64;
  localparam int TICKET_WIDTH = 16;
  localparam int IDX_W        = $clog2(SLOTS);
  localparam int CNT_W        = $clog2(SLOTS + 1);
  localparam int SUM_W        = TICKET_WIDTH + IDX_W;
  localparam int RND_W        = 32;
  localparam int DIV_CNT_W    = $clog2(RND_W + 1);

  localparam int SLOT_IDX_FW = 6;
  localparam int MODE_FW     = 2;
  localparam int TICKET_FW   = 16;
  localparam int RESULT_FW   = 22;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_DRAW  = 1'b1;

  localparam logic [MODE_FW-1:0] MODE_UNUSED   = 2'd0;
  localparam logic [MODE_FW-1:0] MODE_WAITING  = 2'd1;
  localparam logic [MODE_FW-1:0] MODE_RUNNABLE = 2'd2;
  localparam logic [MODE_FW-1:0] MODE_INVALID  = 2'd3;

  typedef struct packed {
    logic                   cmd;
    logic [SLOT_IDX_FW-1:0] slot_index;
    logic [MODE_FW-1:0]     slot_mode;
    logic [TICKET_FW-1:0]   ticket_count;
    logic [RND_W-1:0]       random_value;
  } in_word_t;

  typedef struct packed {
    logic                   winner_found;
    logic [SLOT_IDX_FW-1:0] winner_slot;
    logic [RESULT_FW-1:0]   drawn_ticket;
    logic [RESULT_FW-1:0]   ticket_total;
  } out_word_t;

  typedef struct packed {
    logic [MODE_FW-1:0]      mode;
    logic [TICKET_WIDTH-1:0] tickets;
  } slot_entry_t;

  localparam int ENTRY_W = $bits(slot_entry_t);

  typedef struct packed {
    logic load;
    logic sum_run;
    logic div_start;
    logic div_run;
    logic walk_start;
    logic walk_run;
  } ctrl_cmd_t;

  typedef struct packed {
    logic sum_done;
    logic total_zero;
    logic div_done;
    logic walk_done;
  } dp_status_t;

endpackage

[sv/lsp_ram.sv]
`timescale 1ns / 1ps

module lsp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[sv/lsp_ctrl.sv]
`timescale 1ns / 1ps

module lsp_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               draw_i,
  input  lsp_pkg::dp_status_t status_i,
  output lsp_pkg::ctrl_cmd_t  cmd_o,
  output logic               busy_o,
  output logic               done_o
);

  import lsp_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_SUM  = 5'b00010,
    ST_DIV  = 5'b00100,
    ST_WALK = 5'b01000,
    ST_DONE = 5'b10000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = draw_i ? ST_SUM : ST_DONE;
        end
      end
      ST_SUM: begin
        cmd_o.sum_run = 1'b1;
        if (status_i.sum_done) begin
          if (status_i.total_zero) begin
            state_d = ST_DONE;
          end else begin
            cmd_o.div_start = 1'b1;
            state_d         = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        cmd_o.div_run = 1'b1;
        if (status_i.div_done) begin
          cmd_o.walk_start = 1'b1;
          state_d          = ST_WALK;
        end
      end
      ST_WALK: begin
        cmd_o.walk_run = 1'b1;
        if (status_i.walk_done) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != ST_IDLE);
  assign done_o = (state_q == ST_DONE);

endmodule

[sv/lsp_dp.sv]
`timescale 1ns / 1ps

module lsp_dp (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  lsp_pkg::in_word_t   req_i,
  input  lsp_pkg::ctrl_cmd_t  cmd_i,
  output lsp_pkg::dp_status_t status_o,
  output lsp_pkg::out_word_t  result_o
);

  import lsp_pkg::*;

  logic [SLOTS-1:0]     slot_vld_q;
  logic [CNT_W-1:0]     cnt_q;
  logic                 rvld_q;
  logic                 vbit_q;
  logic [IDX_W-1:0]     ridx_q;
  logic [SUM_W-1:0]     total_q;
  logic [SUM_W-1:0]     rem_q;
  logic [SUM_W-1:0]     cum_q;
  logic [RND_W-1:0]     div_sh_q;
  logic [DIV_CNT_W-1:0] div_cnt_q;
  logic                 found_q;
  logic [IDX_W-1:0]     win_q;

  logic             scan;
  logic [IDX_W-1:0] raddr;
  slot_entry_t      rd_entry;
  logic [MODE_FW-1:0] mode_eff;
  logic             in_use;
  logic [SUM_W-1:0] tickets_ext;
  logic [SUM_W-1:0] cum_end;
  logic             hit;
  logic [SUM_W:0]   trial;
  logic [SUM_W:0]   trial_diff;
  logic             cfg_wr;
  logic             win_wr;
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  slot_entry_t      ram_wdata;

  assign scan        = cmd_i.sum_run | cmd_i.walk_run;
  assign raddr       = cnt_q[IDX_W-1:0];
  assign mode_eff    = vbit_q ? rd_entry.mode : MODE_UNUSED;
  assign in_use      = rvld_q && (mode_eff != MODE_UNUSED);
  assign tickets_ext = SUM_W'(rd_entry.tickets);
  assign cum_end     = cum_q + tickets_ext;
  assign hit         = cmd_i.walk_run && in_use && (rem_q >= cum_q) && (rem_q < cum_end);
  assign trial       = {rem_q, div_sh_q[RND_W-1]};
  assign trial_diff  = trial - {1'b0, total_q};

  assign cfg_wr = cmd_i.load && (req_i.cmd == CMD_WRITE) && (req_i.slot_mode != MODE_INVALID)
                  && (32'(req_i.slot_index) < SLOTS);
  assign win_wr = hit && (mode_eff == MODE_RUNNABLE);

  always_comb begin
    ram_we    = cfg_wr | win_wr;
    ram_waddr = ridx_q;
    ram_wdata = '{mode: MODE_WAITING, tickets: rd_entry.tickets};
    if (cfg_wr) begin
      ram_waddr = IDX_W'(req_i.slot_index);
      ram_wdata = '{mode: req_i.slot_mode, tickets: TICKET_WIDTH'(req_i.ticket_count)};
    end
  end

  lsp_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SLOTS)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (raddr),
    .rdata_o (rd_entry)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_vld_q <= '0;
      cnt_q      <= '0;
      rvld_q     <= 1'b0;
      div_cnt_q  <= '0;
      found_q    <= 1'b0;
    end else begin
      if (cfg_wr) begin
        slot_vld_q[IDX_W'(req_i.slot_index)] <= 1'b1;
      end
      if (cmd_i.load || cmd_i.walk_start) begin
        cnt_q  <= '0;
        rvld_q <= 1'b0;
      end else if (scan) begin
        if (cnt_q != CNT_W'(SLOTS)) begin
          cnt_q  <= cnt_q + CNT_W'(1);
          rvld_q <= 1'b1;
        end else begin
          rvld_q <= 1'b0;
        end
      end
      if (cmd_i.div_start) begin
        div_cnt_q <= '0;
      end else if (cmd_i.div_run && (div_cnt_q != DIV_CNT_W'(RND_W))) begin
        div_cnt_q <= div_cnt_q + DIV_CNT_W'(1);
      end
      if (cmd_i.load) begin
        found_q <= 1'b0;
      end else if (win_wr) begin
        found_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    vbit_q <= slot_vld_q[raddr];
    ridx_q <= raddr;
    if (cmd_i.load) begin
      total_q  <= '0;
      rem_q    <= '0;
      div_sh_q <= req_i.random_value;
      win_q    <= '0;
    end else begin
      if (cmd_i.sum_run && in_use) begin
        total_q <= total_q + tickets_ext;
      end
      if (cmd_i.div_run && (div_cnt_q != DIV_CNT_W'(RND_W))) begin
        rem_q    <= trial_diff[SUM_W] ? trial[SUM_W-1:0] : trial_diff[SUM_W-1:0];
        div_sh_q <= {div_sh_q[RND_W-2:0], 1'b0};
      end
      if (win_wr) begin
        win_q <= ridx_q;
      end
    end
    if (cmd_i.walk_start) begin
      cum_q <= '0;
    end else if (cmd_i.walk_run && in_use) begin
      cum_q <= cum_end;
    end
  end

  assign status_o.sum_done   = (cnt_q == CNT_W'(SLOTS)) && !rvld_q;
  assign status_o.total_zero = (total_q == '0);
  assign status_o.div_done   = (div_cnt_q == DIV_CNT_W'(RND_W));
  assign status_o.walk_done  = hit || ((cnt_q == CNT_W'(SLOTS)) && !rvld_q);

  assign result_o.winner_found = found_q;
  assign result_o.winner_slot  = SLOT_IDX_FW'(win_q);
  assign result_o.drawn_ticket = RESULT_FW'(rem_q);
  assign result_o.ticket_total = RESULT_FW'(total_q);

endmodule

[sv/lottery_slot_picker.sv]
`timescale 1ns / 1ps

// Lottery scheduler over a table of task slots held in a slot memory with one read and one
// write port. A word is taken when start is high and busy is low, and its result word appears
// on result_o for exactly one cycle with result_valid_o high; the receiver cannot stall it, so
// it must take the word in that cycle. A slot write returns an all-zero result in the cycle
// right after it is taken, and the next word can be taken once that result has been shown.
// A draw reads every slot once to form the ticket total, reduces the random value by a
// one-bit-per-cycle remainder unit and reads the slots a second time until the winning
// range is found; a draw with a zero ticket total ends after the first pass. The two passes
// over the slot memory and the remainder unit set how long a draw takes.
// busy stays high until the result word has been shown.
module lottery_slot_picker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  lsp_pkg::in_word_t   req_i,
  output logic               result_valid_o,
  output lsp_pkg::out_word_t  result_o
);

  import lsp_pkg::*;

  ctrl_cmd_t  ctrl_cmd;
  dp_status_t dp_status;

  lsp_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .draw_i   (req_i.cmd == CMD_DRAW),
    .status_i (dp_status),
    .cmd_o    (ctrl_cmd),
    .busy_o   (busy),
    .done_o   (result_valid_o)
  );

  lsp_dp u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (req_i),
    .cmd_i    (ctrl_cmd),
    .status_o (dp_status),
    .result_o (result_o)
  );

endmodule
